// File: hdl/ter_pkg.sv
// Shared types and constants of the tunnel echo responder.
package ter_pkg;

	localparam int SLOT_DEPTH       = 64;
	localparam int SLOT_AW          = $clog2(SLOT_DEPTH);
	localparam int TEXT_MAX_DEFAULT = 48;
	localparam int REQ_PREFIX       = 11;
	localparam int BAUD_BYTES       = 4;
	localparam int QUEUE_DEPTH      = 2;
	localparam int QUEUE_AW         = $clog2(QUEUE_DEPTH);
	localparam int NUM_CNT          = 5;

	localparam int CNT_HANDLED = 0;
	localparam int CNT_DUP     = 1;
	localparam int CNT_BUSY    = 2;
	localparam int CNT_REJ     = 3;
	localparam int CNT_SENT    = 4;

	localparam logic [7:0] REQ_TYPE = 8'd1;
	localparam logic [7:0] RSP_TYPE = 8'd2;

	typedef enum logic [2:0] {
		CFG_LOCAL_SYSTEM  = 3'd0,
		CFG_OWN_COMPONENT = 3'd1,
		CFG_TUNNEL_TYPE   = 3'd2,
		CFG_PROTO_VERSION = 3'd3,
		CFG_LINK_BAUD     = 3'd4
	} ter_cfg_idx_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_IDLE      = 3'd1,
		ST_INVALID   = 3'd2,
		ST_BUSY      = 3'd3,
		ST_NOT_READY = 3'd4
	} ter_status_t;

	typedef enum logic [1:0] {
		ACT_REQ_BYTE = 2'd0,
		ACT_READ_OUT = 2'd1,
		ACT_RELEASE  = 2'd2,
		ACT_BAD      = 2'd3
	} ter_act_t;

	// one classified word as it travels from front to back
	typedef struct packed {
		ter_act_t   act;
		logic       kind_ok;
		logic       addr_ok;
		logic [7:0] src_system;
		logic [7:0] src_component;
		logic [7:0] wire_length;
		logic [7:0] data_byte;
		logic       data_last;
	} ter_cmd_t;

	// registers the back end needs
	typedef struct packed {
		logic [7:0]  protocol_version;
		logic [31:0] link_baud;
	} ter_cfg_t;

endpackage

// File: hdl/tunnel_echo_responder_top.sv
// Top level of the tunnel echo responder.
// Input channel (in_valid/in_stall) takes one word per action: a request byte with its
// header fields, a read out of the pending response, or a release after sending.
// Output channel (out_valid/out_stall) returns status words; a request byte gives a word
// only when marked last, a read out gives one word per stored response byte, or one if none is held.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata), written while idle.
// Front end classifies words into a two-entry queue; back end executes from its head.
// Throughput: one input word per cycle while in_stall is low; a read out holds the back end
// until its last response byte is sent, with stored bytes fetched by a registered slot memory read.
// A result word reaches the outputs through the queue entry register and then the output register.
// When out_stall is high the result word holds and the back end waits; the queue fills and
// then in_stall rises. Non-final request bytes keep flowing while a result waits.
// Reset clears configuration to its defaults, empties the slot and queue and zeroes the
// counters; slot memory contents are not cleared and no startup pass is needed.
module tunnel_echo_responder_top import ter_pkg::*; #(
	parameter int TEXT_MAX = TEXT_MAX_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [7:0]  src_system,
	input  logic [7:0]  src_component,
	input  logic [7:0]  dst_system,
	input  logic [7:0]  dst_component,
	input  logic [15:0] payload_kind,
	input  logic [7:0]  wire_length,
	input  logic [7:0]  data_byte,
	input  logic        data_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [7:0]  resp_byte,
	output logic        resp_last,
	output logic [5:0]  resp_length,
	output logic [7:0]  reply_system,
	output logic [7:0]  reply_component,
	output logic [31:0] handled_count,
	output logic [31:0] duplicate_count,
	output logic [31:0] busy_count,
	output logic [31:0] rejected_count,
	output logic [31:0] sent_count
);

	logic     q_full, q_push, q_pop, head_valid;
	ter_cmd_t push_cmd, head_cmd;
	ter_cfg_t back_cfg;

	ter_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.action        (action),
		.src_system    (src_system),
		.src_component (src_component),
		.dst_system    (dst_system),
		.dst_component (dst_component),
		.payload_kind  (payload_kind),
		.wire_length   (wire_length),
		.data_byte     (data_byte),
		.data_last     (data_last),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_cmd         (push_cmd),
		.back_cfg      (back_cfg)
	);

	ter_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	ter_back #(
		.TEXT_MAX (TEXT_MAX)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (back_cfg),
		.q_valid         (head_valid),
		.q_cmd           (head_cmd),
		.q_pop           (q_pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.resp_byte       (resp_byte),
		.resp_last       (resp_last),
		.resp_length     (resp_length),
		.reply_system    (reply_system),
		.reply_component (reply_component),
		.handled_count   (handled_count),
		.duplicate_count (duplicate_count),
		.busy_count      (busy_count),
		.rejected_count  (rejected_count),
		.sent_count      (sent_count)
	);

endmodule

// File: hdl/ter_front.sv
// Front end: configuration registers, input acceptance and word classification.
module ter_front import ter_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [7:0]  src_system,
	input  logic [7:0]  src_component,
	input  logic [7:0]  dst_system,
	input  logic [7:0]  dst_component,
	input  logic [15:0] payload_kind,
	input  logic [7:0]  wire_length,
	input  logic [7:0]  data_byte,
	input  logic        data_last,
	input  logic        q_full,
	output logic        q_push,
	output ter_cmd_t    q_cmd,
	output ter_cfg_t    back_cfg
);

	logic [7:0]  local_system_q;
	logic [7:0]  own_component_q;
	logic [15:0] tunnel_type_q;
	logic [7:0]  proto_version_q;
	logic [31:0] link_baud_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_system_q  <= 8'd0;
			own_component_q <= 8'd1;
			tunnel_type_q   <= 16'd0;
			proto_version_q <= 8'd1;
			link_baud_q     <= 32'd0;
		end else if (cfg_we) begin
			unique case (ter_cfg_idx_t'(cfg_index))
				CFG_LOCAL_SYSTEM:  local_system_q  <= cfg_wdata[7:0];
				CFG_OWN_COMPONENT: own_component_q <= cfg_wdata[7:0];
				CFG_TUNNEL_TYPE:   tunnel_type_q   <= cfg_wdata[15:0];
				CFG_PROTO_VERSION: proto_version_q <= cfg_wdata[7:0];
				CFG_LINK_BAUD:     link_baud_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_cmd.act           = ter_act_t'(action);
		q_cmd.kind_ok       = (payload_kind == tunnel_type_q);
		q_cmd.addr_ok       = (src_system != 8'd0) && (src_component != 8'd0) &&
			(local_system_q != 8'd0) && (dst_system == local_system_q) &&
			(dst_component == own_component_q);
		q_cmd.src_system    = src_system;
		q_cmd.src_component = src_component;
		q_cmd.wire_length   = wire_length;
		q_cmd.data_byte     = data_byte;
		q_cmd.data_last     = data_last;
	end

	assign back_cfg.protocol_version = proto_version_q;
	assign back_cfg.link_baud        = link_baud_q;

endmodule

// File: hdl/ter_queue.sv
// Short queue of classified words between front and back.
module ter_queue import ter_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  ter_cmd_t push_cmd,
	output logic     full,
	input  logic     pop,
	output logic     head_valid,
	output ter_cmd_t head_cmd
);

	ter_cmd_t              entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_AW:0]     count_q;
	logic                  do_pop;

	assign full       = (count_q == (QUEUE_AW + 1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = entry_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/ter_back.sv
// Back end: request assembly and judging, response slot, read out, counters, output register.
module ter_back import ter_pkg::*; #(
	parameter int TEXT_MAX = TEXT_MAX_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ter_cfg_t    cfg,
	input  logic        q_valid,
	input  ter_cmd_t    q_cmd,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [7:0]  resp_byte,
	output logic        resp_last,
	output logic [5:0]  resp_length,
	output logic [7:0]  reply_system,
	output logic [7:0]  reply_component,
	output logic [31:0] handled_count,
	output logic [31:0] duplicate_count,
	output logic [31:0] busy_count,
	output logic [31:0] rejected_count,
	output logic [31:0] sent_count
);

	typedef enum logic [1:0] {
		BK_IDLE = 2'b01,
		BK_READ = 2'b10
	} ter_bstate_t;

	ter_bstate_t        state_q, state_n;
	logic [SLOT_AW-1:0] rp_q, rp_n;
	logic [7:0]         rx_count_q, rx_count_n;
	logic [7:0]         rx_text_q, rx_text_n;
	logic               rx_hdr_q, rx_hdr_n;
	logic               rx_match_q, rx_match_n;
	logic               slot_valid_q, slot_valid_n;
	logic [7:0]         slot_sys_q, slot_sys_n;
	logic [7:0]         slot_comp_q, slot_comp_n;
	logic [5:0]         slot_len_q, slot_len_n;
	logic [31:0]        slot_baud_q, slot_baud_n;
	logic [31:0]        cnt_q [NUM_CNT];
	logic [31:0]        cnt_n [NUM_CNT];

	logic [7:0]         slot_mem [SLOT_DEPTH];
	logic [7:0]         rd_q;
	logic [SLOT_AW-1:0] rd_addr;
	logic               mem_we;

	logic               out_valid_q;
	ter_status_t        out_status_q, st;
	logic [7:0]         out_byte_q, obyte;
	logic               out_last_q, olast;
	logic               load_out, out_free;

	// per-byte evaluation
	logic [7:0]         idx, b;
	logic               in_slot, hdr_b, match_b;
	logic [7:0]         txt_b, count_b;
	logic [8:0]         len9;
	logic               bad, dup;

	// read out byte selection
	logic [5:0]         baud_base, baud_off;
	logic [7:0]         baud_byte, ro_byte;

	assign out_free = !out_valid_q || !out_stall;

	assign idx     = rx_count_q;
	assign b       = q_cmd.data_byte;
	assign in_slot = (idx < 8'(SLOT_DEPTH));
	assign hdr_b   = rx_hdr_q &&
		!((idx == 8'd0) && (b != cfg.protocol_version)) &&
		!((idx == 8'd1) && (b != REQ_TYPE));
	assign txt_b   = (idx == 8'd10) ? b : rx_text_q;
	assign match_b = rx_match_q && in_slot &&
		!(slot_valid_q && (idx >= 8'd2) && (rd_q != b));
	assign count_b = (idx == 8'hFF) ? idx : idx + 8'd1;
	assign len9    = {1'b0, count_b};

	assign bad = !q_cmd.addr_ok ||
		(len9 < 9'(REQ_PREFIX + 1)) || (len9 > 9'(REQ_PREFIX + TEXT_MAX)) ||
		(q_cmd.wire_length < count_b) || !hdr_b ||
		(txt_b == 8'd0) || (txt_b > 8'(TEXT_MAX)) ||
		(len9 != 9'(REQ_PREFIX) + {1'b0, txt_b});
	assign dup = match_b && (q_cmd.src_system == slot_sys_q) &&
		(q_cmd.src_component == slot_comp_q) &&
		({3'b000, slot_len_q} == len9 + 9'(BAUD_BYTES));

	assign baud_base = slot_len_q - 6'(BAUD_BYTES);
	assign baud_off  = rp_q - baud_base;

	always_comb begin
		unique case (baud_off[1:0])
			2'd0: baud_byte = slot_baud_q[7:0];
			2'd1: baud_byte = slot_baud_q[15:8];
			2'd2: baud_byte = slot_baud_q[23:16];
			2'd3: baud_byte = slot_baud_q[31:24];
			default: baud_byte = 8'd0;
		endcase
	end

	// byte 1 and the appended baud are not read from the slot memory
	always_comb begin
		priority if (rp_q == 6'd1) begin
			ro_byte = RSP_TYPE;
		end else if (rp_q >= baud_base) begin
			ro_byte = baud_byte;
		end else begin
			ro_byte = rd_q;
		end
	end

	always_comb begin
		state_n      = state_q;
		rp_n         = rp_q;
		rx_count_n   = rx_count_q;
		rx_text_n    = rx_text_q;
		rx_hdr_n     = rx_hdr_q;
		rx_match_n   = rx_match_q;
		slot_valid_n = slot_valid_q;
		slot_sys_n   = slot_sys_q;
		slot_comp_n  = slot_comp_q;
		slot_len_n   = slot_len_q;
		slot_baud_n  = slot_baud_q;
		cnt_n        = cnt_q;
		q_pop        = 1'b0;
		load_out     = 1'b0;
		mem_we       = 1'b0;
		st           = ST_OK;
		obyte        = 8'd0;
		olast        = 1'b1;

		unique case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					unique case (q_cmd.act)
						ACT_REQ_BYTE: begin
							if (!q_cmd.data_last || out_free) begin
								q_pop  = 1'b1;
								mem_we = in_slot && !slot_valid_q;
								if (!q_cmd.data_last) begin
									rx_count_n = count_b;
									rx_text_n  = txt_b;
									rx_hdr_n   = hdr_b;
									rx_match_n = match_b;
								end else begin
									load_out   = 1'b1;
									rx_count_n = 8'd0;
									rx_text_n  = 8'd0;
									rx_hdr_n   = 1'b1;
									rx_match_n = 1'b1;
									priority if (!q_cmd.kind_ok) begin
										st = ST_IDLE;
									end else if (bad) begin
										st = ST_INVALID;
										cnt_n[CNT_REJ] = cnt_q[CNT_REJ] + 32'd1;
									end else if (slot_valid_q) begin
										if (dup) begin
											st = ST_OK;
											cnt_n[CNT_DUP] = cnt_q[CNT_DUP] + 32'd1;
										end else begin
											st = ST_BUSY;
											cnt_n[CNT_BUSY] = cnt_q[CNT_BUSY] + 32'd1;
										end
									end else if (cfg.link_baud == 32'd0) begin
										st = ST_NOT_READY;
										cnt_n[CNT_REJ] = cnt_q[CNT_REJ] + 32'd1;
									end else begin
										st           = ST_OK;
										slot_valid_n = 1'b1;
										slot_sys_n   = q_cmd.src_system;
										slot_comp_n  = q_cmd.src_component;
										slot_len_n   = 6'(len9 + 9'(BAUD_BYTES));
										slot_baud_n  = cfg.link_baud;
										cnt_n[CNT_HANDLED] = cnt_q[CNT_HANDLED] + 32'd1;
									end
								end
							end
						end
						ACT_READ_OUT: begin
							if (slot_valid_q) begin
								q_pop   = 1'b1;
								state_n = BK_READ;
								rp_n    = '0;
							end else if (out_free) begin
								q_pop    = 1'b1;
								load_out = 1'b1;
								st       = ST_NOT_READY;
							end
						end
						ACT_RELEASE: begin
							if (out_free) begin
								q_pop    = 1'b1;
								load_out = 1'b1;
								if (slot_valid_q) begin
									st           = ST_OK;
									slot_valid_n = 1'b0;
									slot_sys_n   = 8'd0;
									slot_comp_n  = 8'd0;
									slot_len_n   = 6'd0;
									if (rx_count_q != 8'd0) begin
										rx_hdr_n = 1'b0;
									end
									cnt_n[CNT_SENT] = cnt_q[CNT_SENT] + 32'd1;
								end else begin
									st = ST_IDLE;
								end
							end
						end
						ACT_BAD: begin
							if (out_free) begin
								q_pop    = 1'b1;
								load_out = 1'b1;
								st       = ST_INVALID;
							end
						end
						default: ;
					endcase
				end
			end
			BK_READ: begin
				if (out_free) begin
					load_out = 1'b1;
					st       = ST_OK;
					obyte    = ro_byte;
					olast    = (rp_q == slot_len_q - 6'd1);
					if (olast) begin
						state_n = BK_IDLE;
						rp_n    = '0;
					end else begin
						rp_n = rp_q + 6'd1;
					end
				end
			end
			default: state_n = BK_IDLE;
		endcase
	end

	// read port always holds the entry that the next cycle will need
	assign rd_addr = (state_n == BK_READ) ? rp_n : rx_count_n[SLOT_AW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[idx[SLOT_AW-1:0]] <= b;
		end
		rd_q <= slot_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			rp_q         <= '0;
			rx_count_q   <= 8'd0;
			rx_text_q    <= 8'd0;
			rx_hdr_q     <= 1'b1;
			rx_match_q   <= 1'b1;
			slot_valid_q <= 1'b0;
			slot_sys_q   <= 8'd0;
			slot_comp_q  <= 8'd0;
			slot_len_q   <= 6'd0;
			slot_baud_q  <= 32'd0;
			for (int i = 0; i < NUM_CNT; i++) begin
				cnt_q[i] <= 32'd0;
			end
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_n;
			rp_q         <= rp_n;
			rx_count_q   <= rx_count_n;
			rx_text_q    <= rx_text_n;
			rx_hdr_q     <= rx_hdr_n;
			rx_match_q   <= rx_match_n;
			slot_valid_q <= slot_valid_n;
			slot_sys_q   <= slot_sys_n;
			slot_comp_q  <= slot_comp_n;
			slot_len_q   <= slot_len_n;
			slot_baud_q  <= slot_baud_n;
			cnt_q        <= cnt_n;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q <= st;
			out_byte_q   <= obyte;
			out_last_q   <= olast;
		end
	end

	// slot and counters change only when a new word is loaded, so they match the held word
	assign out_valid       = out_valid_q;
	assign status          = out_status_q;
	assign resp_byte       = out_byte_q;
	assign resp_last       = out_last_q;
	assign resp_length     = slot_len_q;
	assign reply_system    = slot_sys_q;
	assign reply_component = slot_comp_q;
	assign handled_count   = cnt_q[CNT_HANDLED];
	assign duplicate_count = cnt_q[CNT_DUP];
	assign busy_count      = cnt_q[CNT_BUSY];
	assign rejected_count  = cnt_q[CNT_REJ];
	assign sent_count      = cnt_q[CNT_SENT];

	a_empty_len: assert property (@(posedge clk) disable iff (!arst_n)
		!slot_valid_q |-> (slot_len_q == 6'd0))
		else $error("empty slot with nonzero length");

	a_read_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_READ) |-> (slot_valid_q && (rp_q < slot_len_q)))
		else $error("read out beyond stored response");

	a_fill_counts: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(slot_valid_q) |->
			(cnt_q[CNT_HANDLED] == $past(cnt_q[CNT_HANDLED]) + 32'd1))
		else $error("slot filled without handled count");

	a_no_load_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> ($stable(out_status_q) && $stable(slot_len_q) &&
			$stable(cnt_q[CNT_REJ])))
		else $error("held word or its slot state changed");

endmodule
